[src/kmer_window_word_encoder_defines.svh]
// Assertion macros shared by the k-mer encoder checker.
`ifndef KMER_WINDOW_WORD_ENCODER_DEFINES_SVH
`define KMER_WINDOW_WORD_ENCODER_DEFINES_SVH

// Implication into the same cycle, switched off while in reset.
`define KWE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Implication into the next cycle, switched off while in reset.
`define KWE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Implication into the next cycle, checked during reset too.
`define KWE_ASSERT_ALWAYS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) else $error(msg);

`endif

[src/kwe_pkg.sv]
// Types, widths, action codes and helpers of the k-mer window word encoder.
package kwe_pkg;

    localparam int ACTION_W   = 2;
    localparam int AMINO_W    = 5;
    localparam int S_TDATA_W  = 8;
    localparam int POS_W      = 32;
    localparam int PREFIX_W   = 26;
    localparam int SUFFIX_W   = 60;
    localparam int M_TDATA_W  = 208;

    localparam logic [ACTION_W-1:0] ACT_SYMBOL  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_BREAK   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_NEW_SEQ = 2'd2;

    // Per-transaction decisions from the control unit to the cell row and output path.
    typedef struct packed {
        logic             shift;
        logic             emit;
        logic [POS_W-1:0] position;
    } ctrl_t;

    // radix ** power, truncated to the prefix width; elaboration use only.
    function automatic logic [PREFIX_W-1:0] radix_pow(input int unsigned radix,
                                                       input int unsigned power);
        logic [PREFIX_W-1:0] w;
        w = PREFIX_W'(1);
        for (int unsigned i = 0; i < power; i++) begin
            w = PREFIX_W'(w * PREFIX_W'(radix));
        end
        return w;
    endfunction

endpackage

[src/kmer_window_word_encoder.sv]
// Top level of the sliding-window k-mer word encoder.
//
//  channel  | dir | tdata                        | tuser       | tlast
//  ---------+-----+------------------------------+-------------+------
//  s_ axis  | in  | amino [4:0], zeros [7:5]     | action[1:0] | -
//  m_ axis  | out | position, fwd/rev words      | -           | -
//
// One transaction in and one word pair out per cycle while m_tready is high.
// An accepted symbol is registered in the cell row load, then the prefix
// sum goes into the output register, which raises m_tvalid.
// The prefix sums add the registered per-cell products of the cell row.
// Reset is synchronous on aresetn and clears counter, fill count and valids;
// the cells hold payload only and are fully rewritten before any emission.
// s_tready drops only when a word waits in the sum stage and the output
// register is stalled by m_tready.
module kmer_window_word_encoder #(
    parameter int PREFIX_SYMBOLS = 6,
    parameter int SUFFIX_SYMBOLS = 12,
    parameter int RADIX          = 20,
    parameter int SYMBOL_BITS    = 5
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [kwe_pkg::S_TDATA_W-1:0]   s_tdata,   // [4:0] amino, [7:5] zero
    input  logic [kwe_pkg::ACTION_W-1:0]    s_tuser,   // [1:0] action
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [31:0] position, [57:32] fwd_prefix, [117:58] fwd_suffix,
    // [143:118] rev_prefix, [203:144] rev_suffix, [207:204] zero
    output logic [kwe_pkg::M_TDATA_W-1:0]   m_tdata
);
    import kwe_pkg::*;

    localparam int WINDOW_LEN = PREFIX_SYMBOLS + SUFFIX_SYMBOLS;

    ctrl_t                  ctrl;
    logic                   accept;
    logic                   out_free;

    // Cell row: cell 0 holds the newest symbol.
    logic [SYMBOL_BITS-1:0] sym      [WINDOW_LEN];
    logic [PREFIX_W-1:0]    fwd_term [WINDOW_LEN];
    logic [PREFIX_W-1:0]    rev_term [WINDOW_LEN];

    logic [PREFIX_W-1:0]    fwd_prefix_sum;
    logic [PREFIX_W-1:0]    rev_prefix_sum;
    logic [SUFFIX_W-1:0]    fwd_suffix_pack;
    logic [SUFFIX_W-1:0]    rev_suffix_pack;

    // Sum stage: one word waiting for the cell products to settle into the sum.
    logic                   pend_reg;
    logic                   pend_next;
    logic [POS_W-1:0]       pos_reg;

    logic                   m_tvalid_reg;
    logic                   m_tvalid_next;
    logic [M_TDATA_W-1:0]   m_tdata_reg;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = !pend_reg || out_free;
    assign accept   = s_tvalid && s_tready;

    kwe_ctrl #(
        .WINDOW_LEN  (WINDOW_LEN),
        .RADIX       (RADIX),
        .SYMBOL_BITS (SYMBOL_BITS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .action  (s_tuser),
        .amino   (s_tdata[AMINO_W-1:0]),
        .ctrl    (ctrl)
    );

    // Forward prefix: cell SUFFIX_SYMBOLS is the least significant digit.
    // Reverse prefix: cell 0 (newest) is the most significant digit.
    for (genvar k = 0; k < WINDOW_LEN; k++) begin : g_cell
        localparam int FWD_EXP = (k >= SUFFIX_SYMBOLS) ? k - SUFFIX_SYMBOLS : 0;
        localparam int REV_EXP = (k < PREFIX_SYMBOLS) ? PREFIX_SYMBOLS - 1 - k : 0;
        localparam logic [PREFIX_W-1:0] W_FWD =
            (k >= SUFFIX_SYMBOLS) ? radix_pow(RADIX, FWD_EXP) : '0;
        localparam logic [PREFIX_W-1:0] W_REV =
            (k < PREFIX_SYMBOLS) ? radix_pow(RADIX, REV_EXP) : '0;

        logic [SYMBOL_BITS-1:0] sym_in;

        if (k == 0) begin : g_head
            assign sym_in = s_tdata[SYMBOL_BITS-1:0];
        end else begin : g_link
            assign sym_in = sym[k-1];
        end

        kwe_cell #(
            .SYM_W      (SYMBOL_BITS),
            .WEIGHT_FWD (W_FWD),
            .WEIGHT_REV (W_REV)
        ) u_cell (
            .aclk     (aclk),
            .shift    (ctrl.shift),
            .sym_in   (sym_in),
            .sym_out  (sym[k]),
            .fwd_term (fwd_term[k]),
            .rev_term (rev_term[k])
        );
    end

    // Zero-weight terms drop out in synthesis; the sums wrap at the prefix width.
    always_comb begin
        fwd_prefix_sum = '0;
        rev_prefix_sum = '0;
        for (int k = 0; k < WINDOW_LEN; k++) begin
            fwd_prefix_sum = fwd_prefix_sum + fwd_term[k];
            rev_prefix_sum = rev_prefix_sum + rev_term[k];
        end
    end

    // Suffix slots: forward newest lowest, reverse oldest lowest.
    always_comb begin
        fwd_suffix_pack = '0;
        rev_suffix_pack = '0;
        for (int i = 0; i < SUFFIX_SYMBOLS; i++) begin
            fwd_suffix_pack[i*SYMBOL_BITS +: SYMBOL_BITS] = sym[i];
            rev_suffix_pack[i*SYMBOL_BITS +: SYMBOL_BITS] = sym[WINDOW_LEN-1-i];
        end
    end

    // A waiting word always leaves when a new transaction is accepted.
    assign pend_next     = accept ? ctrl.emit : (pend_reg && !out_free);
    assign m_tvalid_next = out_free ? pend_reg : m_tvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && ctrl.emit) begin
            pos_reg <= ctrl.position;
        end
        if (pend_reg && out_free) begin
            m_tdata_reg <= {(M_TDATA_W - POS_W - 2*PREFIX_W - 2*SUFFIX_W)'(0),
                            rev_suffix_pack, rev_prefix_sum,
                            fwd_suffix_pack, fwd_prefix_sum, pos_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

[src/kwe_cell.sv]
// One window cell: holds a symbol and its weighted prefix contributions.
module kwe_cell #(
    parameter int                            SYM_W      = 5,
    parameter logic [kwe_pkg::PREFIX_W-1:0]  WEIGHT_FWD = '0,
    parameter logic [kwe_pkg::PREFIX_W-1:0]  WEIGHT_REV = '0
) (
    input  logic                            aclk,
    input  logic                            shift,
    input  logic [SYM_W-1:0]                sym_in,
    output logic [SYM_W-1:0]                sym_out,
    output logic [kwe_pkg::PREFIX_W-1:0]    fwd_term,
    output logic [kwe_pkg::PREFIX_W-1:0]    rev_term
);
    import kwe_pkg::*;

    logic [SYM_W-1:0]    sym_reg;
    logic [PREFIX_W-1:0] fwd_term_reg;
    logic [PREFIX_W-1:0] rev_term_reg;
    logic [PREFIX_W-1:0] fwd_term_next;
    logic [PREFIX_W-1:0] rev_term_next;

    // Constant weights: synthesis reduces these to a few shifted adds.
    assign fwd_term_next = PREFIX_W'(PREFIX_W'(sym_in) * WEIGHT_FWD);
    assign rev_term_next = PREFIX_W'(PREFIX_W'(sym_in) * WEIGHT_REV);

    always_ff @(posedge aclk) begin
        if (shift) begin
            sym_reg      <= sym_in;
            fwd_term_reg <= fwd_term_next;
            rev_term_reg <= rev_term_next;
        end
    end

    assign sym_out  = sym_reg;
    assign fwd_term = fwd_term_reg;
    assign rev_term = rev_term_reg;

endmodule

[src/kwe_ctrl.sv]
// Symbol counter, window fill count and emit decision.
module kwe_ctrl #(
    parameter int WINDOW_LEN  = 18,
    parameter int RADIX       = 20,
    parameter int SYMBOL_BITS = 5
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          accept,
    input  logic [kwe_pkg::ACTION_W-1:0]  action,
    input  logic [kwe_pkg::AMINO_W-1:0]   amino,
    output kwe_pkg::ctrl_t                ctrl
);
    import kwe_pkg::*;

    localparam int FILL_W = $clog2(WINDOW_LEN + 1);

    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [FILL_W-1:0] fill_inc;
    logic [POS_W-1:0]  count_reg;
    logic [POS_W-1:0]  count_next;
    logic [POS_W-1:0]  count_inc;
    logic              sym_ok;

    // Out-of-range codes behave as a break.
    assign sym_ok = (action == ACT_SYMBOL)
                 && ({1'b0, amino} < (AMINO_W + 1)'(RADIX))
                 && ((amino >> SYMBOL_BITS) == '0);

    assign count_inc = (&count_reg) ? count_reg : count_reg + 1'b1;
    assign fill_inc  = (fill_reg == FILL_W'(WINDOW_LEN)) ? fill_reg : fill_reg + 1'b1;

    always_comb begin
        fill_next  = fill_reg;
        count_next = count_reg;
        ctrl.shift = 1'b0;
        ctrl.emit  = 1'b0;
        // Start of the window, taken from the post-increment (saturated) count.
        ctrl.position = count_inc - POS_W'(WINDOW_LEN);
        if (accept) begin
            if (action == ACT_NEW_SEQ) begin
                fill_next  = '0;
                count_next = '0;
            end else begin
                count_next = count_inc;
                if (sym_ok) begin
                    fill_next  = fill_inc;
                    ctrl.shift = 1'b1;
                    ctrl.emit  = (fill_inc == FILL_W'(WINDOW_LEN));
                end else begin
                    fill_next = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg  <= '0;
            count_reg <= '0;
        end else begin
            fill_reg  <= fill_next;
            count_reg <= count_next;
        end
    end

endmodule

[src/kwe_checker.sv]
// Port-level checker for the k-mer encoder, bound to the top level.
`include "kmer_window_word_encoder_defines.svh"

module kwe_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [kwe_pkg::S_TDATA_W-1:0]   s_tdata,
    input logic [kwe_pkg::ACTION_W-1:0]    s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [kwe_pkg::M_TDATA_W-1:0]   m_tdata
);
    import kwe_pkg::*;

    logic s_sym_txn;

    assign s_sym_txn = s_tvalid && s_tready && (s_tuser == ACT_SYMBOL);

    // Stalled output word holds.
    `KWE_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output changed while stalled")

    // Reset empties the output register.
    `KWE_ASSERT_ALWAYS(a_reset_empty, !aresetn, !m_tvalid, "output valid after reset")

    // A fresh word must come from an earlier symbol transaction.
    `KWE_ASSERT_NOW(a_word_source, $rose(m_tvalid), $past(s_sym_txn, 2), "word without a symbol")

    // Input back-pressure only while the output is stalled.
    `KWE_ASSERT_NOW(a_ready_cause, !s_tready, m_tvalid && !m_tready, "s_tready low without stall")

    logic unused_data;
    assign unused_data = ^s_tdata;

endmodule

bind kmer_window_word_encoder kwe_checker u_kwe_checker (.*);

[test/kmer_window_word_encoder_tb.sv]
// Self-checking testbench for the k-mer window word encoder: directed, random and backpressure runs.
`timescale 1ns / 100ps

module kmer_window_word_encoder_tb;
    import kwe_pkg::*;

    localparam int PREFIX_SYMBOLS = 6;
    localparam int SUFFIX_SYMBOLS = 12;
    localparam int RADIX          = 20;
    localparam int SYMBOL_BITS    = 5;
    localparam int WINDOW_LEN     = PREFIX_SYMBOLS + SUFFIX_SYMBOLS;

    localparam longint unsigned LEAD_WEIGHT = 64'(RADIX) ** (PREFIX_SYMBOLS - 1);
    localparam longint unsigned SYM_MASK    = (64'd1 << SYMBOL_BITS) - 1;
    localparam longint unsigned SUFFIX_MASK = (64'd1 << (SUFFIX_SYMBOLS * SYMBOL_BITS)) - 1;
    localparam int              TOP_SHIFT   = SYMBOL_BITS * (SUFFIX_SYMBOLS - 1);

    // action 3 has no name in the package; the block treats it as a break
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    localparam int DRAIN_CYCLES = 6;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 200_000;
    localparam int PRINT_LIMIT  = 40;

    typedef struct packed {
        logic [POS_W-1:0]    position;
        logic [PREFIX_W-1:0] fwd_prefix;
        logic [SUFFIX_W-1:0] fwd_suffix;
        logic [PREFIX_W-1:0] rev_prefix;
        logic [SUFFIX_W-1:0] rev_suffix;
    } kmer_word_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic [ACTION_W-1:0]   s_tuser  = ACT_SYMBOL;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    kmer_window_word_encoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor state
    int unsigned       win_fill  = 0;
    logic [POS_W-1:0]  seq_count = '0;
    longint unsigned   fwd_pre   = 0;
    longint unsigned   fwd_suf   = 0;
    longint unsigned   rev_pre   = 0;
    longint unsigned   rev_suf   = 0;

    kmer_word_t pending_words[$];
    int         err_count    = 0;
    int         cycle_count  = 0;
    int         src_idle_pct = 0;
    int         sink_idle_pct = 0;
    logic       sink_hold    = 1'b0;
    event       sink_hold_req;

    // Advances the window by one symbol; returns 1 when a word pair comes out.
    function automatic bit encode_symbol(input logic [ACTION_W-1:0] act,
                                         input logic [AMINO_W-1:0] amino,
                                         output kmer_word_t word);
        longint unsigned out_sym;
        word = '0;
        if (act == ACT_NEW_SEQ) begin
            win_fill  = 0;
            seq_count = '0;
            fwd_pre   = 0;
            fwd_suf   = 0;
            rev_pre   = 0;
            rev_suf   = 0;
            return 1'b0;
        end
        if (seq_count != '1)
            seq_count++;
        // breaks, action 3 and codes beyond the alphabet all restart the fill
        if (act != ACT_SYMBOL || amino >= RADIX) begin
            win_fill = 0;
            return 1'b0;
        end
        out_sym = (fwd_suf >> TOP_SHIFT) & SYM_MASK;
        fwd_pre = (fwd_pre % LEAD_WEIGHT) * RADIX + out_sym;
        fwd_suf = ((fwd_suf << SYMBOL_BITS) & SUFFIX_MASK) | 64'(amino);
        out_sym = (rev_pre % RADIX) & SYM_MASK;
        rev_pre = (rev_pre / RADIX) % LEAD_WEIGHT + 64'(amino) * LEAD_WEIGHT;
        rev_suf = ((rev_suf >> SYMBOL_BITS) | (out_sym << TOP_SHIFT)) & SUFFIX_MASK;
        if (win_fill < WINDOW_LEN)
            win_fill++;
        if (win_fill < WINDOW_LEN)
            return 1'b0;
        word.position   = seq_count - POS_W'(WINDOW_LEN);
        word.fwd_prefix = fwd_pre[PREFIX_W-1:0];
        word.fwd_suffix = fwd_suf[SUFFIX_W-1:0];
        word.rev_prefix = rev_pre[PREFIX_W-1:0];
        word.rev_suffix = rev_suf[SUFFIX_W-1:0];
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        if (err_count < PRINT_LIMIT)
            $display("ERROR at %0t ns: %s", $time, msg);
        err_count++;
    endtask

    // input side: predict on every accepted transaction
    always @(posedge aclk) begin
        kmer_word_t word;
        if (aresetn && s_tvalid && s_tready) begin
            if (encode_symbol(s_tuser, s_tdata[AMINO_W-1:0], word))
                pending_words.push_back(word);
        end
    end

    // output side: compare each accepted word pair with the oldest prediction
    always @(posedge aclk) begin
        kmer_word_t got;
        kmer_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.position   = m_tdata[POS_W-1:0];
            got.fwd_prefix = m_tdata[POS_W +: PREFIX_W];
            got.fwd_suffix = m_tdata[POS_W+PREFIX_W +: SUFFIX_W];
            got.rev_prefix = m_tdata[POS_W+PREFIX_W+SUFFIX_W +: PREFIX_W];
            got.rev_suffix = m_tdata[POS_W+2*PREFIX_W+SUFFIX_W +: SUFFIX_W];
            if (pending_words.size() == 0) begin
                report_mismatch($sformatf("unexpected result, position %0d", got.position));
            end else begin
                want = pending_words.pop_front();
                if (got.position !== want.position)
                    report_mismatch($sformatf("position got %0d want %0d",
                                              got.position, want.position));
                if (got.fwd_prefix !== want.fwd_prefix)
                    report_mismatch($sformatf("fwd_prefix got %0d want %0d (pos %0d)",
                                              got.fwd_prefix, want.fwd_prefix, want.position));
                if (got.fwd_suffix !== want.fwd_suffix)
                    report_mismatch($sformatf("fwd_suffix got %h want %h (pos %0d)",
                                              got.fwd_suffix, want.fwd_suffix, want.position));
                if (got.rev_prefix !== want.rev_prefix)
                    report_mismatch($sformatf("rev_prefix got %0d want %0d (pos %0d)",
                                              got.rev_prefix, want.rev_prefix, want.position));
                if (got.rev_suffix !== want.rev_suffix)
                    report_mismatch($sformatf("rev_suffix got %h want %h (pos %0d)",
                                              got.rev_suffix, want.rev_suffix, want.position));
            end
        end
    end

    // receiver: random stalls, or a long hold-off when requested
    always @(posedge aclk) begin
        m_tready <= !sink_hold && ($urandom_range(99) >= sink_idle_pct);
    end

    always begin
        @(sink_hold_req);
        sink_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        sink_hold <= 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Offers one transaction, with a random gap first; returns once accepted.
    task automatic send_symbol(input logic [ACTION_W-1:0] act, input logic [AMINO_W-1:0] amino);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {{(S_TDATA_W-AMINO_W){1'b0}}, amino};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Alternating extreme codes fill the window; the last two symbols emit.
    task automatic test_full_window();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        for (int k = 0; k <= WINDOW_LEN; k++)
            send_symbol(ACT_SYMBOL, (k % 2 == 0) ? AMINO_W'(RADIX - 1) : '0);
        wait_results_drained();
    endtask

    // Break, codes past the alphabet, action 3 and a new sequence.
    task automatic test_special_symbols();
        send_symbol(ACT_BREAK, AMINO_W'(RADIX - 1));
        send_symbol(ACT_SYMBOL, AMINO_W'(RADIX));
        send_symbol(ACT_SYMBOL, '1);
        send_symbol(ACT_UNUSED, AMINO_W'(3));
        send_symbol(ACT_NEW_SEQ, '0);
        wait_results_drained();
    endtask

    // Runs of valid codes, mostly long enough to fill the window, each ended
    // by a break of some kind, a new sequence or nothing at all.
    task automatic test_random_runs(input int n_items, input int src_pct, input int sink_pct);
        int sent;
        int run_len;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        sent = 0;
        while (sent < n_items) begin
            run_len = ($urandom_range(4) == 0) ? $urandom_range(1, WINDOW_LEN - 1)
                                               : $urandom_range(WINDOW_LEN, 64);
            for (int k = 0; k < run_len; k++)
                send_symbol(ACT_SYMBOL, AMINO_W'($urandom_range(RADIX - 1)));
            case ($urandom_range(4))
                0: send_symbol(ACT_BREAK, AMINO_W'($urandom_range(31)));
                1: send_symbol(ACT_UNUSED, AMINO_W'($urandom_range(31)));
                2: send_symbol(ACT_SYMBOL, AMINO_W'($urandom_range(31, RADIX)));
                3: send_symbol(ACT_NEW_SEQ, AMINO_W'($urandom_range(31)));
                default: ;
            endcase
            sent += run_len + 1;
        end
        wait_results_drained();
    endtask

    // Long receiver hold-off while the sender keeps offering, then a pause
    // mid-sequence until every word pair is out, then the sequence resumes.
    task automatic test_output_backpressure();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        send_symbol(ACT_NEW_SEQ, '0);
        -> sink_hold_req;
        for (int k = 0; k < 60; k++)
            send_symbol(ACT_SYMBOL, AMINO_W'($urandom_range(RADIX - 1)));
        wait_results_drained();
        for (int k = 0; k < 20; k++)
            send_symbol(ACT_SYMBOL, AMINO_W'($urandom_range(RADIX - 1)));
        wait_results_drained();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_full_window();
        test_special_symbols();
        test_random_runs(600, 8, 58);
        test_random_runs(600, 58, 8);
        test_output_backpressure();
        test_random_runs(600, 0, 0);

        wait_results_drained();
        if (err_count == 0 && pending_words.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
